>>> src/spad_pkg.sv
package spad_pkg;

  localparam int IDX_W     = 8;
  localparam int CNT_W     = 9;
  localparam int ANGLE_W   = 16;
  localparam int SPIKE_W   = 32;
  localparam int INDEX_W   = 40;
  localparam int MAG_W     = 16;
  localparam int REG_IDX_W = 2;
  localparam int CFG_W     = 16;

  localparam logic [REG_IDX_W-1:0] REG_MIN_ANGLE    = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_MAX_ANGLE    = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_NEURON_COUNT = 2'd2;

  localparam logic [CNT_W-1:0]   NEURON_COUNT_RST = 9'd256;
  localparam logic [ANGLE_W-1:0] MIN_ANGLE_RST    = 16'd0;
  localparam logic [ANGLE_W-1:0] MAX_ANGLE_RST    = 16'd23040;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_MUL,
    ST_DIV,
    ST_OUT
  } state_e;

endpackage

>>> src/spad_if.sv
interface spad_in_if;
  logic                         valid;
  logic                         ready;
  logic [spad_pkg::IDX_W-1:0]   neuron_index;
  logic                         spike_valid;
  logic                         end_of_frame;

  modport source (output valid, neuron_index, spike_valid, end_of_frame, input ready);
  modport sink   (input valid, neuron_index, spike_valid, end_of_frame, output ready);
endinterface

interface spad_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [spad_pkg::ANGLE_W-1:0] angle;
  logic                               saturated;

  modport source (output valid, angle, saturated, input ready);
  modport sink   (input valid, angle, saturated, output ready);
endinterface

>>> src/spad_accum.sv
module spad_accum #(
  parameter int NW = 9
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          step_i,
  input  logic [spad_pkg::IDX_W-1:0]    idx_i,
  input  logic                          spike_i,
  input  logic [NW-1:0]                 n_i,
  output logic [spad_pkg::SPIKE_W-1:0]  spike_total_o,
  output logic [spad_pkg::INDEX_W-1:0]  index_total_o,
  output logic                          sat_o,
  output logic                          nz_next_o
);

  logic [spad_pkg::SPIKE_W-1:0] spike_total_q;
  logic [spad_pkg::INDEX_W-1:0] index_total_q;
  logic                         sat_q;
  logic                         hit;
  logic                         over;
  logic [spad_pkg::INDEX_W:0]   index_sum;

  always_comb begin
    hit       = step_i && spike_i && (NW'(idx_i) < n_i);
    index_sum = {1'b0, index_total_q} + (spad_pkg::INDEX_W + 1)'(idx_i);
    over      = (spike_total_q == '1) || index_sum[spad_pkg::INDEX_W];
    nz_next_o = (spike_total_q != '0) || (hit && !over);
  end

  // A spike that would overflow either total is dropped and sets the sticky flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spike_total_q <= '0;
      index_total_q <= '0;
      sat_q         <= 1'b0;
    end else if (hit) begin
      if (over) begin
        sat_q <= 1'b1;
      end else begin
        spike_total_q <= spike_total_q + 1'b1;
        index_total_q <= index_sum[spad_pkg::INDEX_W-1:0];
      end
    end
  end

  assign spike_total_o = spike_total_q;
  assign index_total_o = index_total_q;
  assign sat_o         = sat_q;

endmodule

>>> src/spad_mul.sv
module spad_mul #(
  parameter int AW = 16,
  parameter int BW = 40
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [AW-1:0]    a_i,
  input  logic [BW-1:0]    b_i,
  output logic             busy_o,
  output logic [AW+BW-1:0] p_o
);

  localparam int CW = $clog2(AW + 1);

  logic [AW+BW-1:0] p_q;
  logic [BW-1:0]    b_q;
  logic [CW-1:0]    cnt_q;
  logic             busy_q;
  logic [BW:0]      part_sum;

  // One multiplier bit per cycle, least significant first; the product shifts right.
  always_comb begin
    part_sum = {1'b0, p_q[AW+BW-1:AW]} + (p_q[0] ? {1'b0, b_q} : '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == CW'(AW - 1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      p_q <= {{BW{1'b0}}, a_i};
      b_q <= b_i;
    end else if (busy_q) begin
      p_q <= {part_sum, p_q[AW-1:1]};
    end
  end

  assign busy_o = busy_q;
  assign p_o    = p_q;

endmodule

>>> src/spad_div.sv
module spad_div #(
  parameter int NDW = 56,
  parameter int DDW = 41
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic [NDW-1:0] dividend_i,
  input  logic [DDW-1:0] divisor_i,
  output logic           busy_o,
  output logic [NDW-1:0] quot_o
);

  localparam int CW = $clog2(NDW + 1);

  logic [NDW-1:0] quo_q;
  logic [DDW-1:0] rem_q;
  logic [DDW-1:0] dvs_q;
  logic [CW-1:0]  cnt_q;
  logic           busy_q;
  logic [DDW:0]   shifted;
  logic [DDW+1:0] trial;
  logic           ge;

  // Restoring division: one quotient bit per cycle, most significant first.
  always_comb begin
    shifted = {rem_q, quo_q[NDW-1]};
    trial   = {1'b0, shifted} - {2'b00, dvs_q};
    ge      = !trial[DDW+1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == CW'(NDW - 1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[NDW-2:0], ge};
      rem_q <= ge ? trial[DDW-1:0] : shifted[DDW-1:0];
    end
  end

  assign busy_o = busy_q;
  assign quot_o = quo_q;

endmodule

>>> src/spike_population_angle_decoder.sv
// Items that yield no angle are taken one per cycle, back to back.
// A frame-end item that yields an angle closes the input while the angle is formed: a load
// state, the bit-serial multipliers (16 and NW bits, NW = bits of the neuron count, 9 by
// default), the 56-step divider and an output state. The angle is valid as the input
// reopens; a held output register adds its wait.
// Reset (rst_ni low, asynchronous) clears the totals, the flag, the controller and output valid.
module spike_population_angle_decoder #(
  parameter int NEURONS = 256
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  spad_in_if.sink                           in_ch,
  spad_out_if.source                        out_ch,
  input  logic                              cfg_we_i,
  input  logic [spad_pkg::REG_IDX_W-1:0]    cfg_idx_i,
  input  logic [spad_pkg::CFG_W-1:0]        cfg_data_i
);

  // Width of the effective neuron count: at least the register width, and
  // enough to hold NEURONS itself.
  localparam int NW = ($clog2(NEURONS + 1) > spad_pkg::CNT_W) ?
                      $clog2(NEURONS + 1) : spad_pkg::CNT_W;
  // Product of span magnitude and index total, and of (n - 1) and spike total.
  localparam int PW = spad_pkg::MAG_W + spad_pkg::INDEX_W;
  localparam int DW = NW + spad_pkg::SPIKE_W;

  // Configuration registers.
  logic signed [spad_pkg::ANGLE_W-1:0] min_angle_q;
  logic signed [spad_pkg::ANGLE_W-1:0] max_angle_q;
  logic [spad_pkg::CNT_W-1:0]          neuron_count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_angle_q    <= spad_pkg::MIN_ANGLE_RST;
      max_angle_q    <= spad_pkg::MAX_ANGLE_RST;
      neuron_count_q <= spad_pkg::NEURON_COUNT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        spad_pkg::REG_MIN_ANGLE:    min_angle_q    <= cfg_data_i;
        spad_pkg::REG_MAX_ANGLE:    max_angle_q    <= cfg_data_i;
        spad_pkg::REG_NEURON_COUNT: neuron_count_q <= cfg_data_i[spad_pkg::CNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Effective neuron count is the register clipped to the population size.
  logic [NW-1:0]  n_eff;
  logic [NW-1:0]  n_less_one;
  logic           single;
  logic [16:0]    span;
  logic           span_neg;
  logic [16:0]    span_abs;
  logic [spad_pkg::MAG_W-1:0] span_mag;

  always_comb begin
    n_eff      = (NW'(neuron_count_q) < NW'(NEURONS)) ? NW'(neuron_count_q) : NW'(NEURONS);
    n_less_one = n_eff - 1'b1;
    single     = (n_eff[NW-1:1] == '0);
    span       = {max_angle_q[15], max_angle_q} - {min_angle_q[15], min_angle_q};
    span_neg   = span[16];
    span_abs   = span_neg ? (17'd0 - span) : span;
    span_mag   = span_abs[spad_pkg::MAG_W-1:0];
  end

  // Controller.
  spad_pkg::state_e state_q, state_d;
  logic accept;
  logic mul_start;
  logic div_start;
  logic out_load;
  logic nz_next;
  logic p_busy;
  logic d_busy;
  logic q_busy;

  assign accept = in_ch.valid && in_ch.ready;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      spad_pkg::ST_IDLE: begin
        if (accept && in_ch.end_of_frame && nz_next) begin
          state_d = spad_pkg::ST_LOAD;
        end
      end
      spad_pkg::ST_LOAD: begin
        state_d = spad_pkg::ST_MUL;
      end
      spad_pkg::ST_MUL: begin
        if (!p_busy && !d_busy) begin
          state_d = spad_pkg::ST_DIV;
        end
      end
      spad_pkg::ST_DIV: begin
        if (!q_busy) begin
          state_d = spad_pkg::ST_OUT;
        end
      end
      spad_pkg::ST_OUT: begin
        if (!out_ch.valid || out_ch.ready) begin
          state_d = spad_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = spad_pkg::ST_IDLE;
      end
    endcase
  end

  // The input is open whenever no frame-end angle is in progress, even while
  // an earlier angle still waits in the output register.
  always_comb begin
    in_ch.ready = 1'b0;
    mul_start   = 1'b0;
    div_start   = 1'b0;
    out_load    = 1'b0;
    unique case (state_q)
      spad_pkg::ST_IDLE: in_ch.ready = 1'b1;
      spad_pkg::ST_LOAD: mul_start   = 1'b1;
      spad_pkg::ST_MUL:  div_start   = !p_busy && !d_busy;
      spad_pkg::ST_DIV: begin
      end
      spad_pkg::ST_OUT:  out_load    = !out_ch.valid || out_ch.ready;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= spad_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Running totals. The spike on a frame-end item is counted at its accept
  // edge, and the multipliers load in the ST_LOAD state after it, so it is included.
  logic [spad_pkg::SPIKE_W-1:0] spike_total;
  logic [spad_pkg::INDEX_W-1:0] index_total;
  logic                         sat_flag;

  spad_accum #(
    .NW (NW)
  ) u_accum (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (accept),
    .idx_i         (in_ch.neuron_index),
    .spike_i       (in_ch.spike_valid),
    .n_i           (n_eff),
    .spike_total_o (spike_total),
    .index_total_o (index_total),
    .sat_o         (sat_flag),
    .nz_next_o     (nz_next)
  );

  // Numerator |span| * index_total and denominator (n - 1) * spike_total are
  // formed in parallel, one multiplier bit per cycle.
  logic [PW-1:0] num;
  logic [DW-1:0] den;
  logic [PW-1:0] quot;

  spad_mul #(
    .AW (spad_pkg::MAG_W),
    .BW (spad_pkg::INDEX_W)
  ) u_mul_num (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (span_mag),
    .b_i     (index_total),
    .busy_o  (p_busy),
    .p_o     (num)
  );

  spad_mul #(
    .AW (NW),
    .BW (spad_pkg::SPIKE_W)
  ) u_mul_den (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (n_less_one),
    .b_i     (spike_total),
    .busy_o  (d_busy),
    .p_o     (den)
  );

  // The quotient is truncated; with a single neuron it is never used.
  spad_div #(
    .NDW (PW),
    .DDW (DW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (num),
    .divisor_i  (den),
    .busy_o     (q_busy),
    .quot_o     (quot)
  );

  // Final angle: min_angle moved toward max_angle by the quotient, then
  // clamped to the signed 16-bit range. A quotient of 2^17 or more always
  // leaves that range, so only its low bits enter the adder.
  logic                                quot_big;
  logic signed [18:0]                  angle_sum;
  logic signed [spad_pkg::ANGLE_W-1:0] angle_res;

  always_comb begin
    quot_big  = |quot[PW-1:17];
    angle_sum = span_neg ?
                ({{3{min_angle_q[15]}}, min_angle_q} - {2'b00, quot[16:0]}) :
                ({{3{min_angle_q[15]}}, min_angle_q} + {2'b00, quot[16:0]});
    priority if (single) begin
      angle_res = min_angle_q;
    end else if (quot_big) begin
      angle_res = span_neg ? 16'sh8000 : 16'sh7fff;
    end else if (angle_sum > 19'sd32767) begin
      angle_res = 16'sh7fff;
    end else if (angle_sum < -19'sd32768) begin
      angle_res = 16'sh8000;
    end else begin
      angle_res = angle_sum[15:0];
    end
  end

  // Output register: holds one finished item until the sink takes it.
  logic                                out_valid_q;
  logic signed [spad_pkg::ANGLE_W-1:0] angle_q;
  logic                                sat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      angle_q <= angle_res;
      sat_q   <= sat_flag;
    end
  end

  assign out_ch.valid     = out_valid_q;
  assign out_ch.angle     = angle_q;
  assign out_ch.saturated = sat_q;

endmodule

>>> tb/sv/spad_angle_checker.sv
module spad_angle_checker #(
  parameter int NEURONS = 256
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  spad_in_if                             in_mon,
  spad_out_if                            out_mon,
  input  logic                           cfg_we_i,
  input  logic [spad_pkg::REG_IDX_W-1:0] cfg_idx_i,
  input  logic [spad_pkg::CFG_W-1:0]     cfg_data_i,
  output int                             angles_pending_o,
  output int                             fail_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import spad_pkg::*;

  typedef struct packed {
    logic signed [ANGLE_W-1:0] angle;
    logic                      saturated;
  } angle_result_t;

  logic signed [ANGLE_W-1:0] min_angle_q;
  logic signed [ANGLE_W-1:0] max_angle_q;
  logic [CNT_W-1:0]          neuron_count_q;
  logic [SPIKE_W-1:0]        spike_total_q;
  logic [INDEX_W-1:0]        index_total_q;
  logic                      saturated_q;
  angle_result_t             angle_queue[$];

  function automatic int unsigned neurons_in_use();
    return (int'(neuron_count_q) < NEURONS) ? int'(neuron_count_q) : NEURONS;
  endfunction

  // Weighted centroid of the spike population, truncated toward zero and
  // saturated to the signed angle range.
  function automatic logic signed [ANGLE_W-1:0] centroid_angle();
    longint unsigned n;
    longint unsigned mag;
    longint unsigned den;
    longint unsigned quot;
    longint          span;
    longint          total;
    n = neurons_in_use();
    if (n <= 1) return min_angle_q;
    span = longint'(max_angle_q) - longint'(min_angle_q);
    mag  = (span < 0) ? -span : span;
    den  = (n - 1) * longint'(spike_total_q);
    if (den == 0) return min_angle_q;
    quot  = (mag * longint'(index_total_q)) / den;
    total = (span < 0) ? longint'(min_angle_q) - longint'(quot)
                       : longint'(min_angle_q) + longint'(quot);
    if (total > 32767) total = 32767;
    if (total < -32768) total = -32768;
    return total[ANGLE_W-1:0];
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    logic [INDEX_W:0] grown;
    angle_result_t    want;
    if (!rst_ni) begin
      min_angle_q    = MIN_ANGLE_RST;
      max_angle_q    = MAX_ANGLE_RST;
      neuron_count_q = NEURON_COUNT_RST;
      spike_total_q  = '0;
      index_total_q  = '0;
      saturated_q    = 1'b0;
      angle_queue.delete();
      angles_pending_o = 0;
      fail_count_o     = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_MIN_ANGLE:    min_angle_q = cfg_data_i;
          REG_MAX_ANGLE:    max_angle_q = cfg_data_i;
          REG_NEURON_COUNT: neuron_count_q = cfg_data_i[CNT_W-1:0];
          default: ;
        endcase
      end

      if (in_mon.valid && in_mon.ready) begin
        if (in_mon.spike_valid && in_mon.neuron_index < neurons_in_use()) begin
          grown = index_total_q + in_mon.neuron_index;
          if (spike_total_q == '1 || grown[INDEX_W]) begin
            saturated_q = 1'b1;
          end else begin
            spike_total_q = spike_total_q + 1'b1;
            index_total_q = grown[INDEX_W-1:0];
          end
        end
        if (in_mon.end_of_frame && spike_total_q != '0) begin
          want.angle     = centroid_angle();
          want.saturated = saturated_q;
          angle_queue.push_back(want);
        end
      end

      if (out_mon.valid && out_mon.ready) begin
        if (angle_queue.size() == 0) begin
          $error("angle result %0d arrived with none expected", out_mon.angle);
          fail_count_o++;
        end else begin
          want = angle_queue.pop_front();
          if (out_mon.angle !== want.angle) begin
            $error("angle: expected %0d, actual %0d", want.angle, out_mon.angle);
            fail_count_o++;
          end
          if (out_mon.saturated !== want.saturated) begin
            $error("saturated: expected %0b, actual %0b", want.saturated,
                   out_mon.saturated);
            fail_count_o++;
          end
        end
      end

      angles_pending_o = angle_queue.size();
    end
  end

endmodule

>>> tb/sv/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import spad_pkg::*;

  localparam int NEURONS = 256;
  // The limit is far above what a slow correct run needs: a few hundred angle
  // results, plus idling and the pauses between settings.
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  // Each pause outlasts the time for which the block holds the input for one
  // angle.
  localparam int SETTLE_CYCLES = 100;
  localparam int PHASE_ITEMS   = 230;
  localparam int RANDOM_PHASES = 8;
  localparam int IDLE_PERCENT  = 24;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [REG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]     cfg_data_i;
  int                   angles_pending;
  int                   fail_count;
  // When calm is set, neither the spike source nor the angle sink idles.
  logic                 calm = 1'b0;
  // Neuron count as the block sees it, used to aim most spikes in range.
  int unsigned          live_neurons;
  int unsigned          cycle_count = 0;

  spad_in_if  in_ch ();
  spad_out_if out_ch ();

  spike_population_angle_decoder #(
    .NEURONS(NEURONS)
  ) i_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i)
  );

  spad_angle_checker #(
    .NEURONS(NEURONS)
  ) i_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_mon          (in_ch),
    .out_mon         (out_ch),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .angles_pending_o(angles_pending),
    .fail_count_o    (fail_count)
  );

  always #2 clk_i = ~clk_i;

  // The angle sink stalls at random, except during the calm stretch.
  always @(negedge clk_i) begin
    out_ch.ready <= calm || ($urandom_range(0, 99) >= IDLE_PERCENT);
  end

  // Watchdog: a hung handshake or a missing result ends the run here.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("spike_population_angle_decoder test failed");
      $finish;
    end
  end

  // Offers one item and returns at the falling edge after it was accepted.
  // Valid is left high so that back-to-back items need no second assignment
  // in the same time step; an idle gap lowers it first.
  task automatic send_item(input logic [IDX_W-1:0] idx, input logic spike,
                           input logic frame_end);
    int gap;
    gap = 0;
    if (!calm) begin
      while ($urandom_range(0, 99) < IDLE_PERCENT) gap++;
    end
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_ch.valid        <= 1'b1;
    in_ch.neuron_index <= idx;
    in_ch.spike_valid  <= spike;
    in_ch.end_of_frame <= frame_end;
    do @(posedge clk_i); while (!in_ch.ready);
    @(negedge clk_i);
  endtask

  // Writes all three registers on consecutive cycles while the block is idle.
  task automatic load_setting(input logic [CFG_W-1:0] lo, input logic [CFG_W-1:0] hi,
                              input logic [CFG_W-1:0] count);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= REG_MIN_ANGLE;
    cfg_data_i <= lo;
    @(negedge clk_i);
    cfg_idx_i  <= REG_MAX_ANGLE;
    cfg_data_i <= hi;
    @(negedge clk_i);
    cfg_idx_i  <= REG_NEURON_COUNT;
    cfg_data_i <= count;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    live_neurons = (count[CNT_W-1:0] < NEURONS) ? count[CNT_W-1:0] : NEURONS;
  endtask

  // Stops the source, waits for every expected angle, then lets the
  // block drain before the next setting.
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (angles_pending != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // Three in four spikes fall inside the population in use; the rest cover
  // the whole index field so that out-of-range spikes are exercised too.
  function automatic logic [IDX_W-1:0] pick_index();
    if (live_neurons > 0 && $urandom_range(0, 99) < 75)
      return IDX_W'($urandom_range(0, live_neurons - 1));
    return IDX_W'($urandom_range(0, 255));
  endfunction

  // Mostly well-formed frames of a few spikes closed by a frame end, now
  // and then closed by an empty marker instead. The remainder is noise with
  // every field at random.
  task automatic send_frames(input int budget);
    int sent;
    int len;
    sent = 0;
    while (sent < budget) begin
      if ($urandom_range(0, 99) < 85) begin
        len = $urandom_range(1, 10);
        for (int k = 0; k < len - 1; k++) begin
          send_item(pick_index(), $urandom_range(0, 19) != 0, 1'b0);
        end
        send_item(pick_index(), $urandom_range(0, 4) != 0, 1'b1);
        sent += len;
      end else begin
        send_item(IDX_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)));
        sent++;
      end
    end
  endtask

  initial begin
    rst_ni             = 1'b0;
    cfg_we_i           = 1'b0;
    cfg_idx_i          = REG_MIN_ANGLE;
    cfg_data_i         = '0;
    in_ch.valid        = 1'b0;
    in_ch.neuron_index = '0;
    in_ch.spike_valid  = 1'b0;
    in_ch.end_of_frame = 1'b0;
    out_ch.ready       = 1'b0;
    live_neurons       = NEURONS;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed items at the reset setting. A frame end before any spike
    // gives no angle, and an empty marker alone is ignored.
    send_item(8'h00, 1'b0, 1'b1);
    send_item(8'hFF, 1'b0, 1'b0);
    // A spike on the closing item is counted before the angle is formed.
    send_item(8'h00, 1'b1, 1'b1);
    send_item(8'hFF, 1'b1, 1'b0);
    send_item(8'hFF, 1'b1, 1'b1);
    send_item(8'hAA, 1'b1, 1'b1);
    send_item(8'h55, 1'b1, 1'b0);
    // A frame closed by an empty marker still reports an angle.
    send_item(8'h00, 1'b0, 1'b1);
    settle();

    // A single neuron: the angle is min_angle, and any other index is ignored.
    load_setting(16'h8000, 16'h7FFF, 16'd1);
    send_item(8'h00, 1'b1, 1'b1);
    send_item(8'hC8, 1'b1, 1'b1);
    settle();

    // A neuron count of zero ignores every spike and still reports min_angle.
    load_setting(16'h7FFF, 16'h8000, 16'd0);
    send_item(8'h00, 1'b1, 1'b1);
    settle();

    // Shrinking the count after high-index spikes pushes the quotient past
    // the span, so the angle saturates high and then low.
    load_setting(16'h0000, 16'h7FFF, 16'd2);
    send_item(8'h01, 1'b1, 1'b1);
    settle();
    load_setting(16'h7FFF, 16'h8000, 16'd2);
    send_item(8'h00, 1'b1, 1'b1);
    settle();

    // A count write with bits above the register width, and a zero span.
    load_setting(16'h1234, 16'h1234, 16'hFF2C);
    send_item(8'hFF, 1'b1, 1'b1);
    settle();

    // Random frames under several settings. The first phase runs without
    // any idling on either side.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: load_setting(MIN_ANGLE_RST, MAX_ANGLE_RST, CFG_W'(NEURON_COUNT_RST));
        1: load_setting(CFG_W'($urandom()), CFG_W'($urandom()),
                        CFG_W'($urandom_range(2, 256)));
        2: load_setting(16'h8000, 16'h7FFF, 16'd256);
        3: load_setting(16'h7FFF, 16'h8000, 16'd255);
        4: load_setting(CFG_W'($urandom()), CFG_W'($urandom()), 16'd16);
        5: load_setting(CFG_W'($urandom()), CFG_W'($urandom()), 16'd2);
        6: load_setting(CFG_W'($urandom()), CFG_W'($urandom()), CFG_W'($urandom()));
        default: load_setting(CFG_W'($urandom()), CFG_W'($urandom()),
                              CFG_W'($urandom_range(200, 256)));
      endcase
      calm = (p == 0);
      send_frames(PHASE_ITEMS);
      settle();
    end

    if (fail_count == 0) begin
      $display("spike_population_angle_decoder test passed");
    end else begin
      $display("spike_population_angle_decoder test failed");
    end
    $finish;
  end

endmodule
